FILE: hw/rtl/tptu_pkg.sv
// Package for the TLB and page-table translator: widths, the controller state type
// and the structs passed between the TLB cells, the page table and the top level.
// No dependencies.
package tptu_pkg;

   localparam int ADDR_W      = 16;
   localparam int OFFSET_BITS = 8;
   localparam int TLB_ENTRIES = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int PAGE_IDX_W  = $clog2(PAGE_COUNT);
   localparam int TAG_W       = 8;
   localparam int FRAME_W     = 8;
   localparam int FREE_W      = 9;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [FRAME_W-1:0] frame;
   } tlb_entry_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tlb_search_type;

   typedef struct packed {
      logic                  rd_en;
      logic [PAGE_IDX_W-1:0] rd_page;
      logic                  wr_en;
      logic [PAGE_IDX_W-1:0] wr_page;
      logic [FRAME_W-1:0]    wr_frame;
   } pt_req_type;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } pt_rsp_type;

endpackage

FILE: hw/rtl/tptu_tlb_cell.sv
// One TLB cell: holds a single page-to-frame mapping, takes its neighbour's entry on a shift
// and passes the search result along the chain. Depends on tptu_pkg.
module tptu_tlb_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  tptu_pkg::tlb_entry_type entry_in,
   output tptu_pkg::tlb_entry_type entry_out,
   input  logic [tptu_pkg::TAG_W-1:0] search_tag,
   input  tptu_pkg::tlb_search_type search_in,
   output tptu_pkg::tlb_search_type search_out
);
   import tptu_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [TAG_W-1:0]   tag_ff;
   logic [TAG_W-1:0]   tag_in;
   logic [FRAME_W-1:0] frame_ff;
   logic [FRAME_W-1:0] frame_in;
   logic               match;

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      frame_in = frame_ff;
      if (shift_en) begin
         valid_in = entry_in.valid;
         tag_in   = entry_in.tag;
         frame_in = entry_in.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      frame_ff <= frame_in;
   end

   // An earlier cell that already matched keeps priority.
   assign match = valid_ff && (tag_ff == search_tag);

   always_comb begin
      search_out = search_in;
      if (!search_in.hit && match) begin
         search_out.hit   = 1'b1;
         search_out.frame = frame_ff;
      end
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.tag   = tag_ff;
   assign entry_out.frame = frame_ff;

endmodule

FILE: hw/rtl/tptu_page_table.sv
// Page table: frame memory with a registered read port and per-page valid bits that
// reset clears. Depends on tptu_pkg.
module tptu_page_table (
   input  logic                 clock,
   input  logic                 reset,
   input  tptu_pkg::pt_req_type pt_req,
   output tptu_pkg::pt_rsp_type pt_rsp
);
   import tptu_pkg::*;

   logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] map_valid_ff;
   logic                  rd_valid_ff;
   logic [FRAME_W-1:0]    rd_frame_ff;

   always_ff @(posedge clock) begin
      if (pt_req.wr_en) begin
         frame_mem[pt_req.wr_page] <= pt_req.wr_frame;
      end
      if (pt_req.rd_en) begin
         rd_frame_ff <= frame_mem[pt_req.rd_page];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (pt_req.wr_en) begin
            map_valid_ff[pt_req.wr_page] <= 1'b1;
         end
         if (pt_req.rd_en) begin
            rd_valid_ff <= map_valid_ff[pt_req.rd_page];
         end
      end
   end

   assign pt_rsp.valid = rd_valid_ff;
   assign pt_rsp.frame = rd_frame_ff;

endmodule

FILE: hw/rtl/tlb_page_table_translator_unit.sv
// Top level of the TLB and page-table translator: controller, chain of TLB cells and
// page table. Depends on tptu_pkg, tptu_tlb_cell and tptu_page_table.
//
//  Channel  Ports                                                  Direction
//  req      req_valid, req_stall, req_logical_address              in
//  rsp      rsp_valid, rsp_stall, rsp_physical_address,
//           rsp_tlb_hit, rsp_page_fault                            out
//
// Each transaction passes through the idle and lookup states: the page-table read is issued on acceptance, and the
// TLB search, fault handling and page-table write-back happen in the lookup state that follows.
// One transaction is in flight at a time, so that a fault's TLB shift and page-table
// write-back are complete before the next lookup reads them.
// Reset clears the TLB valid bits, the page-table valid bits and the free-frame counter.
// A stalled result holds the lookup state until the output register is free.
module tlb_page_table_translator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tptu_pkg::ADDR_W-1:0] req_logical_address,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tptu_pkg::ADDR_W-1:0] rsp_physical_address,
   output logic                        rsp_tlb_hit,
   output logic                        rsp_page_fault
);
   import tptu_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  addr_in;
   logic [FREE_W-1:0]  free_ff;
   logic [FREE_W-1:0]  free_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [ADDR_W-1:0]  rsp_addr_in;
   logic               rsp_hit_ff;
   logic               rsp_hit_in;
   logic               rsp_fault_ff;
   logic               rsp_fault_in;

   logic               accept;
   logic               finish;
   logic               fault;
   logic [FRAME_W-1:0] frame;
   logic [TAG_W-1:0]   cur_tag;
   logic [PAGE_IDX_W-1:0] req_page;
   logic [PAGE_IDX_W-1:0] cur_page;
   logic [OFFSET_BITS-1:0] cur_offset;

   pt_req_type     pt_req;
   pt_rsp_type     pt_rsp;
   tlb_entry_type  entry_chain  [TLB_ENTRIES+1];
   tlb_search_type search_chain [TLB_ENTRIES+1];

   assign req_page   = req_logical_address[OFFSET_BITS +: PAGE_IDX_W];
   assign cur_page   = addr_ff[OFFSET_BITS +: PAGE_IDX_W];
   assign cur_offset = addr_ff[OFFSET_BITS-1:0];
   assign cur_tag    = TAG_W'(cur_page);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         ST_LOOKUP: begin
            finish = !rsp_valid_ff || !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   tptu_page_table u_page_table (
      .clock  (clock),
      .reset  (reset),
      .pt_req (pt_req),
      .pt_rsp (pt_rsp)
   );

   assign entry_chain[0].valid  = 1'b1;
   assign entry_chain[0].tag    = cur_tag;
   assign entry_chain[0].frame  = frame;
   assign search_chain[0].hit   = 1'b0;
   assign search_chain[0].frame = '0;

   for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      tptu_tlb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (finish && fault),
         .entry_in   (entry_chain[i]),
         .entry_out  (entry_chain[i+1]),
         .search_tag (cur_tag),
         .search_in  (search_chain[i]),
         .search_out (search_chain[i+1])
      );
   end

   always_comb begin
      fault = !search_chain[TLB_ENTRIES].hit && !pt_rsp.valid;
      if (search_chain[TLB_ENTRIES].hit) begin
         frame = search_chain[TLB_ENTRIES].frame;
      end else if (fault) begin
         frame = free_ff[FRAME_W-1:0];
      end else begin
         frame = pt_rsp.frame;
      end
   end

   always_comb begin
      pt_req.rd_en    = accept;
      pt_req.rd_page  = req_page;
      pt_req.wr_en    = finish && fault;
      pt_req.wr_page  = cur_page;
      pt_req.wr_frame = frame;
   end

   always_comb begin
      addr_in      = accept ? req_logical_address : addr_ff;
      free_in      = (finish && fault) ? free_ff + FREE_W'(1) : free_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = ADDR_W'({frame, cur_offset});
         rsp_hit_in   = search_chain[TLB_ENTRIES].hit;
         rsp_fault_in = fault;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;

endmodule

FILE: bench/tptu_translation_checker.sv
`timescale 1ns / 1ps
// Checker for the TLB and page-table translator: it watches both channels, predicts every
// translation and compares each result transaction with the oldest prediction.
// Depends on tptu_pkg.
module tptu_translation_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [tptu_pkg::ADDR_W-1:0] req_logical_address,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [tptu_pkg::ADDR_W-1:0] rsp_physical_address,
   input  logic                        rsp_tlb_hit,
   input  logic                        rsp_page_fault,
   output int                          failures,
   output int                          outstanding
);
   import tptu_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] physical_address;
      logic              tlb_hit;
      logic              page_fault;
   } translation_type;

   logic [TAG_W-1:0]             tlb_tags      [TLB_ENTRIES];
   logic [FRAME_W-1:0]           tlb_frames    [TLB_ENTRIES];
   logic [$clog2(TLB_ENTRIES):0] tlb_count;
   logic [FRAME_W-1:0]           frame_of_page [PAGE_COUNT];
   logic                         page_mapped   [PAGE_COUNT];
   logic [FREE_W-1:0]            free_frame;
   translation_type              pending_translations [$];

   function automatic translation_type translate_address(input logic [ADDR_W-1:0] address);
      logic [PAGE_IDX_W-1:0] page;
      logic [FRAME_W-1:0]    frame;
      translation_type       result;
      page = PAGE_IDX_W'((address >> OFFSET_BITS) % PAGE_COUNT);
      frame = '0;
      result = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (!result.tlb_hit && i < tlb_count && tlb_tags[i] == TAG_W'(page)) begin
            result.tlb_hit = 1'b1;
            frame = tlb_frames[i];
         end
      end
      if (!result.tlb_hit) begin
         if (page_mapped[page]) begin
            frame = frame_of_page[page];
         end else begin
            result.page_fault = 1'b1;
            frame = free_frame[FRAME_W-1:0];
            frame_of_page[page] = frame;
            page_mapped[page] = 1'b1;
            free_frame = free_frame + 1'b1;
            for (int i = TLB_ENTRIES - 1; i > 0; i--) begin
               tlb_tags[i] = tlb_tags[i-1];
               tlb_frames[i] = tlb_frames[i-1];
            end
            tlb_tags[0] = TAG_W'(page);
            tlb_frames[0] = frame;
            if (tlb_count < TLB_ENTRIES) begin
               tlb_count = tlb_count + 1'b1;
            end
         end
      end
      result.physical_address = ADDR_W'({frame, address[OFFSET_BITS-1:0]});
      return result;
   endfunction

   always @(posedge clock) begin
      translation_type expected;
      int              errors;
      errors = 0;
      if (reset) begin
         tlb_count = '0;
         free_frame = '0;
         for (int p = 0; p < PAGE_COUNT; p++) begin
            page_mapped[p] = 1'b0;
         end
         pending_translations.delete();
         failures <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_translations.size() == 0) begin
               $error("result transaction with nothing expected: physical_address %h",
                      rsp_physical_address);
               errors++;
            end else begin
               expected = pending_translations.pop_front();
               if (rsp_physical_address !== expected.physical_address) begin
                  $error("physical_address: expected %h, got %h",
                         expected.physical_address, rsp_physical_address);
                  errors++;
               end
               if (rsp_tlb_hit !== expected.tlb_hit) begin
                  $error("tlb_hit: expected %b, got %b", expected.tlb_hit, rsp_tlb_hit);
                  errors++;
               end
               if (rsp_page_fault !== expected.page_fault) begin
                  $error("page_fault: expected %b, got %b",
                         expected.page_fault, rsp_page_fault);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_translations.push_back(translate_address(req_logical_address));
         end
         failures <= failures + errors;
      end
      outstanding <= pending_translations.size();
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for the TLB and page-table translator: clock, reset, address
// stimulus, result stalls and the verdict. Depends on tptu_pkg, the translator and
// tptu_translation_checker.
module testbench;
   import tptu_pkg::*;

   localparam int RANDOM_ITEMS   = 1250;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_ALTERNATE
   } stall_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ADDR_W-1:0] req_logical_address = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_physical_address;
   logic              rsp_tlb_hit;
   logic              rsp_page_fault;
   int                failures;
   int                outstanding;
   int                idle_cycles = 0;
   logic              long_hold_req = 1'b0;
   bit                page_sent [PAGE_COUNT];
   logic [PAGE_IDX_W-1:0] recent_pages [$];

   always #1 clock = ~clock;

   tlb_page_table_translator_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault)
   );

   tptu_translation_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .failures             (failures),
      .outstanding          (outstanding)
   );

   task automatic send_translation(input logic [ADDR_W-1:0] address);
      logic [PAGE_IDX_W-1:0] page;
      page = PAGE_IDX_W'(address >> OFFSET_BITS);
      if (!page_sent[page]) begin
         page_sent[page] = 1'b1;
         recent_pages.push_front(page);
         if (recent_pages.size() > TLB_ENTRIES) begin
            void'(recent_pages.pop_back());
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_logical_address <= address;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // The result side stalls on a pattern of its own, apart from one long hold-off
   // that lets the translator fill up and stall its input.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      logic           phase;
      bit             hold_done;
      mode = STALL_NONE;
      mode_left = 0;
      phase = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(3));
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            phase = ~phase;
            case (mode)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(3) == 0);
               end
               STALL_HEAVY: begin
                  rsp_stall <= ($urandom_range(3) != 0);
               end
               default: begin
                  rsp_stall <= phase;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tlb_page_table_translator_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      logic [ADDR_W-1:0]     address;
      logic [PAGE_IDX_W-1:0] fresh;
      int                    burst_left;
      int                    start;
      int                    choice;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fault on the lowest and highest page, TLB hits with extreme offsets, then enough
      // faults to push page zero out of the TLB, which must then hit in the page table
      // twice without being refilled.
      send_translation(16'h0000);
      send_translation(16'h00FF);
      send_translation(16'hFFFF);
      send_translation(16'hFF00);
      for (int p = 1; p < TLB_ENTRIES; p++) begin
         send_translation(ADDR_W'((p << OFFSET_BITS) | ((p % 2) ? 'hA5 : 'h5A)));
      end
      send_translation(16'h0012);
      send_translation(16'h0034);
      send_translation(16'hFF55);
      send_translation(16'h0F80);
      wait_for_drain();

      long_hold_req <= 1'b1;
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         choice = $urandom_range(99);
         address = ADDR_W'($urandom);
         if (choice < 20) begin
            start = $urandom_range(PAGE_COUNT - 1);
            for (int k = 0; k < PAGE_COUNT; k++) begin
               if (!page_sent[(start + k) % PAGE_COUNT]) begin
                  fresh = PAGE_IDX_W'((start + k) % PAGE_COUNT);
                  address = ADDR_W'({fresh, address[OFFSET_BITS-1:0]});
                  break;
               end
            end
         end else if (choice < 65 && recent_pages.size() > 0) begin
            fresh = recent_pages[$urandom_range(recent_pages.size() - 1)];
            address = ADDR_W'({fresh, address[OFFSET_BITS-1:0]});
         end
         send_translation(address);
         if (n == RANDOM_ITEMS / 2) begin
            wait_for_drain();
         end else if (n >= 60) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(3) != 0) begin
                  idle_sender($urandom_range(1, 8));
               end
            end
            burst_left--;
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tlb_page_table_translator_unit: match");
      end else begin
         $display("tlb_page_table_translator_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tptu_pkg.sv
hw/rtl/tptu_tlb_cell.sv
hw/rtl/tptu_page_table.sv
hw/rtl/tlb_page_table_translator_unit.sv
bench/tptu_translation_checker.sv
bench/testbench.sv
